/* rtl/bat_pkg.sv */
// ----------------------------------------------------------------------------
// bat_pkg
// Shared types and constants for the breakpoint address table.
// ----------------------------------------------------------------------------
package bat_pkg;

  localparam int DefEntries   = 16;
  localparam int DefFlagWidth = 16;
  localparam int AddrWidth    = 64;
  localparam int PortFlagW    = 16;

  typedef enum logic [1:0] {
    KIND_SET       = 2'd0,
    KIND_CLEAR     = 2'd1,
    KIND_LOOKUP    = 2'd2,
    KIND_CLEAR_ALL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FAIL = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    kind_t                kind;
    logic [AddrWidth-1:0] address;
    logic                 any_match;
    logic                 compare;
    logic                 commit;
  } cmd_t;

endpackage

/* rtl/bat_cell.sv */
// ----------------------------------------------------------------------------
// bat_cell
// One table entry: compares against the command and applies its update,
// passing the free-slot priority to its neighbor.
// ----------------------------------------------------------------------------
module bat_cell
  import bat_pkg::*;
#(
  parameter int FLAG_WIDTH = DefFlagWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [FLAG_WIDTH-1:0] cmd_fb,
  input  logic                  free_in,
  output logic                  free_out,
  output logic                  match,
  output logic                  no_common,
  output logic [FLAG_WIDTH-1:0] flags_out
);

  logic                  valid;
  logic                  valid_next;
  logic [AddrWidth-1:0]  address;
  logic [AddrWidth-1:0]  address_next;
  logic [FLAG_WIDTH-1:0] flags;
  logic [FLAG_WIDTH-1:0] flags_next;
  logic [FLAG_WIDTH-1:0] cleared;
  logic                  free_q;
  logic                  take;
  logic                  common;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      match  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (cmd.compare) begin
        match  <= valid && (address == cmd.address);
        free_q <= !valid;
      end
      if (cmd.commit) begin
        valid <= valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      address <= address_next;
      flags   <= flags_next;
    end
  end

  assign take     = free_q && !free_in;
  assign free_out = free_in || free_q;
  assign common   = |(flags & cmd_fb);
  assign cleared  = flags & ~cmd_fb;

  always_comb begin
    valid_next   = valid;
    address_next = address;
    flags_next   = flags;
    case (cmd.kind)
      KIND_SET: begin
        if (match) begin
          flags_next = flags | cmd_fb;
        end else if (!cmd.any_match && take) begin
          valid_next   = 1'b1;
          address_next = cmd.address;
          flags_next   = cmd_fb;
        end
      end
      KIND_CLEAR: begin
        if (match && common) begin
          flags_next = cleared;
          if (cleared == '0) begin
            valid_next = 1'b0;
          end
        end
      end
      KIND_LOOKUP: begin
      end
      KIND_CLEAR_ALL: begin
        valid_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign no_common = match && !common;
  assign flags_out = match ? flags_next : '0;

endmodule

/* rtl/breakpoint_address_table_core.sv */
// An input transfer is registered, then compared in the cell row, then committed with
// free-slot priority rippling along the row into the output register.
// A new command is taken only while idle or while its predecessor commits.
// A waiting result stalls the commit until it is taken; the input stays closed.
// Reset (synchronous) empties the table by clearing every valid bit.
// ----------------------------------------------------------------------------
// breakpoint_address_table_core
// Breakpoint address table built as a row of entry cells with set, clear,
// lookup and clear-all commands.
// ----------------------------------------------------------------------------
module breakpoint_address_table_core
  import bat_pkg::*;
#(
  parameter int ENTRIES    = DefEntries,
  parameter int FLAG_WIDTH = DefFlagWidth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           kind,
  input  logic [AddrWidth-1:0] address,
  input  logic [PortFlagW-1:0] flag_bits,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic                 hit,
  output logic [PortFlagW-1:0] entry_flags
);

  state_t                state;
  state_t                state_next;
  kind_t                 kind_q;
  logic [AddrWidth-1:0]  addr_q;
  logic [FLAG_WIDTH-1:0] fb_q;
  logic [FLAG_WIDTH-1:0] fb_in;
  logic                  accept;
  logic                  commit;
  logic                  any_match;
  logic                  any_no_common;
  logic                  full;
  cmd_t                  cmd;
  logic [ENTRIES:0]      free_chain;
  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES-1:0]    no_common_vec;
  logic [FLAG_WIDTH-1:0] cell_flags [ENTRIES];
  logic [FLAG_WIDTH-1:0] res_flags;
  logic [PortFlagW-1:0]  res_flags_port;
  status_t               res_status;
  logic                  res_hit;

  generate
    if (FLAG_WIDTH <= PortFlagW) begin : g_narrow
      assign fb_in = flag_bits[FLAG_WIDTH-1:0];
      assign res_flags_port = PortFlagW'(res_flags);
    end else begin : g_wide
      assign fb_in = {{(FLAG_WIDTH-PortFlagW){1'b0}}, flag_bits};
      assign res_flags_port = res_flags[PortFlagW-1:0];
    end
  endgenerate

  assign commit   = (state == ST_UPD) && (!out_valid || !out_stall);
  assign in_stall = !((state == ST_IDLE) || commit);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD: begin
        if (commit) begin
          state_next = accept ? ST_CMP : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind_t'(kind);
      addr_q <= address;
      fb_q   <= fb_in;
    end
  end

  assign cmd.kind      = kind_q;
  assign cmd.address   = addr_q;
  assign cmd.any_match = any_match;
  assign cmd.compare   = (state == ST_CMP);
  assign cmd.commit    = commit;

  assign free_chain[0] = 1'b0;

  generate
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      bat_cell #(
        .FLAG_WIDTH(FLAG_WIDTH)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmd),
        .cmd_fb   (fb_q),
        .free_in  (free_chain[i]),
        .free_out (free_chain[i+1]),
        .match    (match_vec[i]),
        .no_common(no_common_vec[i]),
        .flags_out(cell_flags[i])
      );
    end
  endgenerate

  assign any_match     = |match_vec;
  assign any_no_common = |no_common_vec;
  assign full          = !free_chain[ENTRIES];

  always_comb begin
    res_flags = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      res_flags = res_flags | cell_flags[i];
    end
  end

  always_comb begin
    res_status = STAT_OK;
    res_hit    = any_match;
    case (kind_q)
      KIND_SET:       if (!any_match && full) res_status = STAT_FULL;
      KIND_CLEAR:     if (!any_match || any_no_common) res_status = STAT_FAIL;
      KIND_LOOKUP:    res_status = STAT_OK;
      KIND_CLEAR_ALL: res_hit = 1'b0;
      default:        res_status = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status      <= res_status;
      hit         <= res_hit;
      entry_flags <= (kind_q == KIND_CLEAR_ALL) ? '0 : res_flags_port;
    end
  end

endmodule

/* rtl/bat_checker.sv */
// ----------------------------------------------------------------------------
// bat_checker
// Port-level checks for the breakpoint address table, bound to the top level.
// ----------------------------------------------------------------------------
module bat_checker
  import bat_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           status,
  input logic                 hit,
  input logic [PortFlagW-1:0] entry_flags
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a transfer in keeps the input closed during the compare cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open during compare");

  // full and miss results carry no flags
  a_full_no_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_FULL) |-> (!hit && entry_flags == '0))
    else $error("full result with hit or flags");

  a_miss_no_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (entry_flags == '0))
    else $error("flags without hit");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(hit)
      && $stable(entry_flags)))
    else $error("stalled result changed");

endmodule

bind breakpoint_address_table_core bat_checker u_bat_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .hit        (hit),
  .entry_flags(entry_flags)
);
